// ===== rtl/core/color_ratio_preserving_rescale_assert.svh =====
// Assertion macros shared by the rescale checker.
`ifndef COLOR_RATIO_PRESERVING_RESCALE_ASSERT_SVH
`define COLOR_RATIO_PRESERVING_RESCALE_ASSERT_SVH

// Check a property on the rising clock edge, ignored while reset is low.
`define CRPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define CRPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/crpr_pkg.sv =====
// Types and constants for the color-ratio-preserving rescale pipeline.
`timescale 1ns / 1ps
`default_nettype none

package crpr_pkg;

  // Sample width and the largest sample value.
  localparam int PIXEL_BITS = 8;
  localparam logic [PIXEL_BITS-1:0] TOPV = '1;

  // Color channels per pixel.
  localparam int NUM_CH = 3;

  // Divider widths: numerator 2*n + d, denominator 2*d, partial remainder.
  localparam int NUM_W = 2 * PIXEL_BITS + 2;
  localparam int DEN_W = PIXEL_BITS + 1;
  localparam int REM_W = PIXEL_BITS + 2;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // Input beat.
  typedef struct packed {
    pix_t red_in;
    pix_t green_in;
    pix_t blue_in;
    pix_t intensity_orig;
    pix_t intensity_new;
    logic frame_end;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    pix_t red_out;
    pix_t green_out;
    pix_t blue_out;
    logic frame_end_out;
  } out_beat_t;

  // Request into the divider: three numerators over one shared denominator.
  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]             den;
    logic                         zero;
    logic                         fend;
  } div_req_t;

  // Response from the divider: three quotients plus the carried flags.
  typedef struct packed {
    logic [NUM_CH-1:0][PIXEL_BITS-1:0] quo;
    logic                              zero;
    logic                              fend;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/crpr_div_pipe.sv =====
// Pipelined restoring divider, three lanes sharing one denominator, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module crpr_div_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_stall,
  input  wire crpr_pkg::div_req_t up_req,
  output logic                   dn_valid,
  input  wire logic              dn_stall,
  output crpr_pkg::div_rsp_t     dn_rsp
);

  localparam int P     = crpr_pkg::PIXEL_BITS;
  localparam int NCH   = crpr_pkg::NUM_CH;
  localparam int NUM_W = crpr_pkg::NUM_W;
  localparam int DEN_W = crpr_pkg::DEN_W;
  localparam int REM_W = crpr_pkg::REM_W;

  typedef struct packed {
    logic [NCH-1:0][REM_W-1:0] rem;
    logic [NCH-1:0][NUM_W-1:0] num;
    logic [NCH-1:0][P-1:0]     quo;
    logic [DEN_W-1:0]          den;
    logic                      zero;
    logic                      fend;
  } step_t;

  step_t st_r  [P];
  logic  v_r   [P];
  step_t src   [P];
  logic  v_src [P];
  logic  [P:0] go;
  step_t seed;

  // Seed the partial remainder with the numerator bits above the quotient.
  always_comb begin
    seed      = '0;
    seed.num  = up_req.num;
    seed.den  = up_req.den;
    seed.zero = up_req.zero;
    seed.fend = up_req.fend;
    for (int k = 0; k < NCH; k++) begin
      seed.rem[k] = up_req.num[k][NUM_W-1:P];
    end
  end

  // A stage advances when empty or when the stage after it advances.
  assign go[P] = !dn_stall;

  for (genvar s = 0; s < P; s++) begin : g_step
    localparam int Bit = P - 1 - s;
    step_t step_nxt;

    if (s == 0) begin : g_first
      assign src[s]   = seed;
      assign v_src[s] = up_valid;
    end else begin : g_next
      assign src[s]   = st_r[s-1];
      assign v_src[s] = v_r[s-1];
    end

    assign go[s] = !v_r[s] || go[s+1];

    // Shift in one numerator bit and subtract the denominator where it fits.
    always_comb begin
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] den_ext;
      step_nxt = src[s];
      den_ext  = {1'b0, src[s].den};
      for (int k = 0; k < NCH; k++) begin
        trial = {src[s].rem[k][REM_W-2:0], src[s].num[k][Bit]};
        if (trial >= den_ext) begin
          step_nxt.rem[k]      = trial - den_ext;
          step_nxt.quo[k][Bit] = 1'b1;
        end else begin
          step_nxt.rem[k] = trial;
        end
      end
    end

    // Hold the stage while stalled; advance valid with the data.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (go[s]) begin
        v_r[s] <= v_src[s];
      end
    end

    always_ff @(posedge clk) begin
      if (go[s] && v_src[s]) begin
        st_r[s] <= step_nxt;
      end
    end
  end

  assign up_stall    = !go[0];
  assign dn_valid    = v_r[P-1];
  assign dn_rsp.quo  = st_r[P-1].quo;
  assign dn_rsp.zero = st_r[P-1].zero;
  assign dn_rsp.fend = st_r[P-1].fend;

endmodule

`default_nettype wire

// ===== rtl/core/color_ratio_preserving_rescale.sv =====
// Top level of the color-ratio-preserving intensity rescale pipeline.
//
// channel  | ports                          | direction
// ---------+--------------------------------+----------
// input    | in_valid, in_stall, in_data    | in
// result   | out_valid, out_stall, out_data | out
//
// One pixel enters per cycle while in_stall is low; the stages are, in order:
// max, select, multiply, one divider stage per quotient bit, then the output register.
// Reset (synchronous, rst_n low) empties every stage; nothing is held over.
// out_stall freezes the stages that are full; bubbles still close up, so in_stall
// rises only when every stage holds a pixel and the output beat is stalled.
`timescale 1ns / 1ps
`default_nettype none

module color_ratio_preserving_rescale (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire crpr_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output crpr_pkg::out_beat_t     out_data
);

  localparam int P     = crpr_pkg::PIXEL_BITS;
  localparam int NCH   = crpr_pkg::NUM_CH;
  localparam int NUM_W = crpr_pkg::NUM_W;

  typedef struct packed {
    crpr_pkg::in_beat_t beat;
    crpr_pkg::pix_t     mx;
  } sta_t;

  typedef struct packed {
    logic [NCH-1:0][P-1:0] ch;
    crpr_pkg::pix_t        mul;
    crpr_pkg::pix_t        div;
    logic                  zero;
    logic                  fend;
  } stb_t;

  sta_t               a_r;
  logic               va_r;
  stb_t               b_r;
  logic               vb_r;
  crpr_pkg::div_req_t c_r;
  logic               vc_r;
  logic               out_valid_r;
  crpr_pkg::out_beat_t out_r;

  logic go_a, go_b, go_c, go_o;
  logic div_up_stall, div_dn_valid;
  crpr_pkg::div_rsp_t div_rsp;

  crpr_pkg::pix_t mx_nxt;
  sta_t           a_nxt;
  stb_t           b_nxt;
  crpr_pkg::div_req_t c_nxt;
  crpr_pkg::out_beat_t out_nxt;

  // Ripple the advance condition back from the output register.
  assign go_o     = !out_valid_r || !out_stall;
  assign go_c     = !vc_r || !div_up_stall;
  assign go_b     = !vb_r || go_c;
  assign go_a     = !va_r || go_b;
  assign in_stall = !go_a;

  // Stage A: largest of the three samples.
  always_comb begin
    mx_nxt = in_data.red_in;
    if (in_data.green_in > mx_nxt) mx_nxt = in_data.green_in;
    if (in_data.blue_in > mx_nxt)  mx_nxt = in_data.blue_in;
    a_nxt.beat = in_data;
    a_nxt.mx   = mx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (go_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_a && in_valid) begin
      a_r <= a_nxt;
    end
  end

  // Stage B: pick the clipped scale (top/max) or the plain one (new/orig).
  always_comb begin
    logic [2*P-1:0] prod;
    logic [2*P-1:0] lim;
    logic           clip;
    prod      = a_r.mx * a_r.beat.intensity_new;
    lim       = {a_r.beat.intensity_orig, {P{1'b0}}} - {{P{1'b0}}, a_r.beat.intensity_orig};
    clip      = prod > lim;
    b_nxt.ch[0] = a_r.beat.red_in;
    b_nxt.ch[1] = a_r.beat.green_in;
    b_nxt.ch[2] = a_r.beat.blue_in;
    b_nxt.mul   = clip ? crpr_pkg::TOPV : a_r.beat.intensity_new;
    b_nxt.div   = clip ? a_r.mx : a_r.beat.intensity_orig;
    b_nxt.zero  = (a_r.beat.intensity_orig == '0);
    b_nxt.fend  = a_r.beat.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (go_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go_b && va_r) begin
      b_r <= b_nxt;
    end
  end

  // Stage C: numerators 2*c*k + d and denominator 2*d for round half up.
  always_comb begin
    logic [2*P-1:0] n;
    for (int k = 0; k < NCH; k++) begin
      n            = b_r.ch[k] * b_r.mul;
      c_nxt.num[k] = {1'b0, n, 1'b0} + NUM_W'(b_r.div);
    end
    c_nxt.den  = {b_r.div, 1'b0};
    c_nxt.zero = b_r.zero;
    c_nxt.fend = b_r.fend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (go_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go_c && vb_r) begin
      c_r <= c_nxt;
    end
  end

  // Divide all three lanes, one quotient bit per stage.
  crpr_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vc_r),
    .up_stall (div_up_stall),
    .up_req   (c_r),
    .dn_valid (div_dn_valid),
    .dn_stall (!go_o),
    .dn_rsp   (div_rsp)
  );

  // Output register: zero intensity forces black, frame end passes through.
  always_comb begin
    out_nxt.red_out       = div_rsp.zero ? '0 : div_rsp.quo[0];
    out_nxt.green_out     = div_rsp.zero ? '0 : div_rsp.quo[1];
    out_nxt.blue_out      = div_rsp.zero ? '0 : div_rsp.quo[2];
    out_nxt.frame_end_out = div_rsp.fend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go_o) begin
      out_valid_r <= div_dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_o && div_dn_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/crpr_checker.sv =====
// Port-level checker for the rescale pipeline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "color_ratio_preserving_rescale_assert.svh"

module crpr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire crpr_pkg::out_beat_t out_data
);

  // Hold a stalled result beat.
  `CRPR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result beat changed")

  // Back-pressure at the input comes only from a stalled result beat.
  `CRPR_ASSERT(a_stall_src, in_stall |-> out_valid && out_stall, "input stalled while output free")

  // Reset leaves the pipeline empty and ready.
  `CRPR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind color_ratio_preserving_rescale crpr_checker u_crpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== test/color_ratio_preserving_rescale_checker.sv =====
// Scoreboard for the rescale block: predicts each pixel's rescaled color and compares it with the result.
`timescale 1ns / 1ps

module color_ratio_preserving_rescale_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  crpr_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  crpr_pkg::out_beat_t out_data,
  output int                  fail_count,
  output int                  pending_pixels
);

  crpr_pkg::out_beat_t rescaled_queue[$];
  crpr_pkg::out_beat_t want;

  initial begin
    fail_count     = 0;
    pending_pixels = 0;
  end

  // Scale one pixel by new/orig intensity, or by top/max when that would clip; zero orig intensity gives black.
  function automatic crpr_pkg::out_beat_t rescale_pixel(crpr_pkg::in_beat_t px);
    int unsigned         chan[3];
    int unsigned         i_orig;
    int unsigned         i_new;
    int unsigned         peak;
    int unsigned         top;
    int unsigned         quo[3];
    crpr_pkg::out_beat_t res;
    chan[0] = px.red_in;
    chan[1] = px.green_in;
    chan[2] = px.blue_in;
    i_orig  = px.intensity_orig;
    i_new   = px.intensity_new;
    top     = crpr_pkg::TOPV;
    peak    = chan[0];
    if (chan[1] > peak) peak = chan[1];
    if (chan[2] > peak) peak = chan[2];
    for (int k = 0; k < 3; k++) begin
      if (i_orig == 0) begin
        quo[k] = 0;
      end else if (peak * i_new > top * i_orig) begin
        // clip path: keep channel ratios, brightest lands on top value
        quo[k] = (2 * chan[k] * top + peak) / (2 * peak);
      end else begin
        quo[k] = (2 * chan[k] * i_new + i_orig) / (2 * i_orig);
      end
    end
    res.red_out       = crpr_pkg::pix_t'(quo[0]);
    res.green_out     = crpr_pkg::pix_t'(quo[1]);
    res.blue_out      = crpr_pkg::pix_t'(quo[2]);
    res.frame_end_out = px.frame_end;
    return res;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Watch both channels: queue a prediction per input beat, check each result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) rescaled_queue.push_back(rescale_pixel(in_data));
      if (out_valid && !out_stall) begin
        if (rescaled_queue.size() == 0) begin
          report_mismatch("result beat with no pixel waiting");
        end else begin
          want = rescaled_queue.pop_front();
          if (out_data.red_out !== want.red_out)
            report_mismatch($sformatf("red_out got %0d expected %0d",
                                      out_data.red_out, want.red_out));
          if (out_data.green_out !== want.green_out)
            report_mismatch($sformatf("green_out got %0d expected %0d",
                                      out_data.green_out, want.green_out));
          if (out_data.blue_out !== want.blue_out)
            report_mismatch($sformatf("blue_out got %0d expected %0d",
                                      out_data.blue_out, want.blue_out));
          if (out_data.frame_end_out !== want.frame_end_out)
            report_mismatch($sformatf("frame_end_out got %0b expected %0b",
                                      out_data.frame_end_out, want.frame_end_out));
        end
      end
      pending_pixels = rescaled_queue.size();
    end
  end

endmodule

// ===== test/color_ratio_preserving_rescale_tb.sv =====
// Top of the rescale testbench: clock, reset, pixel stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module color_ratio_preserving_rescale_tb;

  localparam int RANDOM_PIXELS = 1200;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 40;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  crpr_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  crpr_pkg::out_beat_t out_data;
  int                  fail_count;
  int                  pending_pixels;

  int        tx_idle_pct = 21;
  int        rx_idle_pct = 61;
  bit        hold_off_req = 1'b0;

  crpr_pkg::in_beat_t directed_pixels[$];

  color_ratio_preserving_rescale DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  color_ratio_preserving_rescale_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_pixels (pending_pixels)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic crpr_pkg::in_beat_t make_pixel(int r, int g, int b, int i_orig, int i_new,
                                                    bit fe);
    crpr_pkg::in_beat_t px;
    px.red_in         = crpr_pkg::pix_t'(r);
    px.green_in       = crpr_pkg::pix_t'(g);
    px.blue_in        = crpr_pkg::pix_t'(b);
    px.intensity_orig = crpr_pkg::pix_t'(i_orig);
    px.intensity_new  = crpr_pkg::pix_t'(i_new);
    px.frame_end      = fe;
    return px;
  endfunction

  // Random pixel: mostly consistent intensity, some arbitrary, a few with zero intensity.
  function automatic crpr_pkg::in_beat_t random_pixel();
    crpr_pkg::in_beat_t px;
    int                 pick;
    pick = $urandom_range(0, 99);
    px = make_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    ($urandom_range(0, 15) == 0));
    if (pick < 80)
      px.intensity_orig = crpr_pkg::pix_t'((px.red_in + px.green_in + px.blue_in + 1) / 3);
    else if (pick < 85)
      px.intensity_orig = '0;
    return px;
  endfunction

  // Offer one pixel after random idle cycles; return once it is accepted.
  task automatic send_pixel(input crpr_pkg::in_beat_t px);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender: reset, directed pixels, then random pixels over three idle phases.
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    directed_pixels.push_back(make_pixel(0, 0, 0, 0, 0, 1'b0));
    directed_pixels.push_back(make_pixel(255, 255, 255, 0, 0, 1'b1));      // zero intensity
    directed_pixels.push_back(make_pixel(17, 200, 90, 0, 255, 1'b0));      // zero intensity
    directed_pixels.push_back(make_pixel(255, 255, 255, 255, 255, 1'b1));
    directed_pixels.push_back(make_pixel(255, 255, 255, 255, 0, 1'b0));
    directed_pixels.push_back(make_pixel(100, 100, 100, 100, 200, 1'b0));
    directed_pixels.push_back(make_pixel(200, 100, 50, 117, 250, 1'b0));   // clips
    directed_pixels.push_back(make_pixel(255, 0, 0, 85, 85, 1'b0));        // right on the edge
    directed_pixels.push_back(make_pixel(1, 3, 5, 2, 1, 1'b0));            // halves round up
    directed_pixels.push_back(make_pixel(255, 255, 255, 1, 1, 1'b0));      // inconsistent
    directed_pixels.push_back(make_pixel(0, 0, 0, 50, 255, 1'b1));
    directed_pixels.push_back(make_pixel(1, 0, 0, 1, 255, 1'b0));
    directed_pixels.push_back(make_pixel(2, 1, 0, 1, 255, 1'b0));          // clip, half up
    directed_pixels.push_back(make_pixel(10, 0, 3, 255, 255, 1'b0));       // inconsistent
    directed_pixels.push_back(make_pixel(170, 85, 255, 170, 85, 1'b1));
    directed_pixels.push_back(make_pixel(85, 170, 0, 85, 170, 1'b0));
    directed_pixels.push_back(make_pixel(255, 254, 1, 170, 255, 1'b0));
    directed_pixels.push_back(make_pixel(128, 128, 128, 128, 1, 1'b0));
    directed_pixels.push_back(make_pixel(255, 255, 255, 1, 255, 1'b1));    // huge gain, clips
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == RANDOM_PIXELS / 3) begin
        tx_idle_pct = 61;
        rx_idle_pct = 21;
      end else if (n == 2 * RANDOM_PIXELS / 3) begin
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b1;
      end
      send_pixel(random_pixel());
    end
    in_valid <= 1'b0;
    // drain the pipeline, then settle
    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_pixels == 0)
      $display("color_ratio_preserving_rescale_tb: PASS");
    else
      $display("color_ratio_preserving_rescale_tb: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the block fills and stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("color_ratio_preserving_rescale_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/crpr_pkg.sv
rtl/core/crpr_div_pipe.sv
rtl/core/color_ratio_preserving_rescale.sv
rtl/core/crpr_checker.sv
test/color_ratio_preserving_rescale_checker.sv
test/color_ratio_preserving_rescale_tb.sv
